/* rtl/ptb_pkg.sv */
// Shared constants and codes for the periodic timer bank.
package ptb_pkg;

  // Bank size and period width.
  localparam int NUM_SLOTS   = 16;
  localparam int PERIOD_BITS = 16;

  // Derived widths.
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int ID_W   = 5;
  localparam int IVAL_W = 16;
  localparam int CFG_W  = 5;

  // Largest period value, held in 32 bits so that every width in range fits.
  localparam logic [31:0] PERIOD_MAX = 32'((64'd1 << PERIOD_BITS) - 64'd1);

  // Request kinds.
  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DEL  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // Result event codes.
  localparam logic [1:0] EV_ADD  = 2'd0;
  localparam logic [1:0] EV_DEL  = 2'd1;
  localparam logic [1:0] EV_EXP  = 2'd2;
  localparam logic [1:0] EV_IDLE = 2'd3;

  // Reset value of the timer limit register.
  localparam logic [CFG_W-1:0] MAX_TIMERS_RST = 5'd16;

endpackage

/* rtl/periodic_timer_bank.sv */
// Periodic timer bank: slot bookkeeping and a one-slot-per-cycle tick sequencer.
// Add and delete: the single result appears in the cycle after the transfer; busy stays low.
// Tick: one slot of the elapsed/period store is updated per cycle through one shared
// increment-and-compare unit; busy stays high through the walk and the closing flush.
// Expiries stream out during the walk; the last result comes from the flush state after it.
// Reset (rst_ni low, asynchronous) frees every slot and sets the timer limit to 16.
module periodic_timer_bank (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        cfg_we_i,
  input  logic [ptb_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [1:0]                  req_type_i,
  input  logic [ptb_pkg::IVAL_W-1:0]  interval_i,
  input  logic [ptb_pkg::ID_W-1:0]    timer_id_i,
  output logic                        res_valid_o,
  output logic [1:0]                  event_res_o,
  output logic [ptb_pkg::ID_W-1:0]    timer_id_res_o,
  output logic                        ok_o,
  output logic                        last_o
);

  localparam int SLOT_W = ptb_pkg::SLOT_W;
  localparam int CNT_W  = ptb_pkg::CNT_W;
  localparam int ID_W   = ptb_pkg::ID_W;
  localparam int PW     = ptb_pkg::PERIOD_BITS;

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [SLOT_W-1:0]          idx_q, idx_d;
  logic [ptb_pkg::NUM_SLOTS-1:0] active_q, active_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [ptb_pkg::CFG_W-1:0]  max_q;
  logic                       pend_q, pend_d;
  logic [ID_W-1:0]            pend_id_q, pend_id_d;

  logic                       res_valid_q, res_valid_d;
  logic [1:0]                 event_q, event_d;
  logic [ID_W-1:0]            id_q, id_d;
  logic                       ok_q, ok_d;
  logic                       last_q, last_d;

  logic [PW-1:0]              period_q  [ptb_pkg::NUM_SLOTS];
  logic [PW-1:0]              elapsed_q [ptb_pkg::NUM_SLOTS];

  logic                       accept;
  logic                       free_found;
  logic [SLOT_W-1:0]          free_idx;
  logic                       del_ok;
  logic [SLOT_W-1:0]          del_idx;
  logic                       add_ok;
  logic [31:0]                ival_ext;
  logic [PW-1:0]              ival_sat;
  logic [PW-1:0]              elapsed_inc;
  logic                       expired;
  logic                       scan_hit;
  logic                       add_we;
  logic                       tick_we;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ptb_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Add admission and interval saturation.
  assign ival_ext = 32'(interval_i);
  assign ival_sat = (ival_ext > ptb_pkg::PERIOD_MAX) ? PW'(ptb_pkg::PERIOD_MAX) : PW'(ival_ext);
  assign add_ok   = (interval_i != '0) && (32'(cnt_q) < 32'(max_q)) && free_found;

  // Delete lookup; the id is range-checked before the slot bit counts.
  assign del_idx = SLOT_W'(timer_id_i - ID_W'(1));
  assign del_ok  = (timer_id_i != '0) && (32'(timer_id_i) <= ptb_pkg::NUM_SLOTS)
                   && active_q[del_idx];

  // Shared increment-and-compare unit, one slot per cycle.
  assign elapsed_inc = elapsed_q[idx_q] + PW'(1);
  assign expired     = (elapsed_inc >= period_q[idx_q]);
  assign scan_hit    = (state_q == ST_SCAN) && active_q[idx_q] && expired;

  assign add_we  = accept && (req_type_i == ptb_pkg::REQ_ADD) && add_ok;
  assign tick_we = (state_q == ST_SCAN) && active_q[idx_q];

  // Control and result next-state logic.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    active_d    = active_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    res_valid_d = 1'b0;
    event_d     = event_q;
    id_d        = id_q;
    ok_d        = ok_q;
    last_d      = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            ptb_pkg::REQ_ADD: begin
              res_valid_d = 1'b1;
              event_d     = ptb_pkg::EV_ADD;
              last_d      = 1'b1;
              ok_d        = add_ok;
              id_d        = add_ok ? (ID_W'(free_idx) + ID_W'(1)) : '0;
              if (add_ok) begin
                active_d[free_idx] = 1'b1;
                cnt_d              = cnt_q + CNT_W'(1);
              end
            end
            ptb_pkg::REQ_DEL: begin
              res_valid_d = 1'b1;
              event_d     = ptb_pkg::EV_DEL;
              last_d      = 1'b1;
              ok_d        = del_ok;
              id_d        = del_ok ? timer_id_i : '0;
              if (del_ok) begin
                active_d[del_idx] = 1'b0;
                cnt_d             = cnt_q - CNT_W'(1);
              end
            end
            ptb_pkg::REQ_TICK: begin
              state_d = ST_SCAN;
              idx_d   = '0;
              pend_d  = 1'b0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // An expiry is held back one find so that the final one can carry last.
        if (scan_hit) begin
          if (pend_q) begin
            res_valid_d = 1'b1;
            event_d     = ptb_pkg::EV_EXP;
            id_d        = pend_id_q;
            ok_d        = 1'b0;
            last_d      = 1'b0;
          end
          pend_d    = 1'b1;
          pend_id_d = ID_W'(idx_q) + ID_W'(1);
        end
        if (idx_q == SLOT_W'(ptb_pkg::NUM_SLOTS - 1)) begin
          state_d = ST_FLUSH;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      ST_FLUSH: begin
        res_valid_d = 1'b1;
        ok_d        = 1'b0;
        last_d      = 1'b1;
        event_d     = pend_q ? ptb_pkg::EV_EXP : ptb_pkg::EV_IDLE;
        id_d        = pend_q ? pend_id_q : '0;
        pend_d      = 1'b0;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      cnt_q       <= '0;
      max_q       <= ptb_pkg::MAX_TIMERS_RST;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    event_q   <= event_d;
    id_q      <= id_d;
    ok_q      <= ok_d;
    last_q    <= last_d;
  end

  // Period and elapsed store: written on a successful add and during the tick walk.
  always_ff @(posedge clk_i) begin
    if (add_we) begin
      period_q[free_idx]  <= ival_sat;
      elapsed_q[free_idx] <= '0;
    end else if (tick_we) begin
      elapsed_q[idx_q] <= expired ? '0 : elapsed_inc;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign event_res_o    = event_q;
  assign timer_id_res_o = id_q;
  assign ok_o           = ok_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  // The active count always matches the number of occupied slots.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == $countones(active_q))
    else $error("active count does not match occupied slots");

  // The sequencer only leaves idle after a transfer.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a transfer");

  // Add and delete replies are single results.
  a_reply_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (event_res_o == ptb_pkg::EV_ADD || event_res_o == ptb_pkg::EV_DEL)
    |-> last_o)
    else $error("add or delete reply without last");

  // A successful reply always names a slot.
  a_ok_has_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && ok_o |-> timer_id_res_o != '0)
    else $error("successful reply with id zero");
`endif

endmodule
